@@ sv/face_flux_accumulator_top_assert.svh @@
// ----------------------------------------------------------------------------
// Face flux accumulator assertion macros
// Concurrent checks that the top level uses; they vanish when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef FACE_FLUX_ACCUMULATOR_TOP_ASSERT_SVH
`define FACE_FLUX_ACCUMULATOR_TOP_ASSERT_SVH
`ifndef SYNTH
`define FFA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("face flux accumulator check failed");
`define FFA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("face flux accumulator check failed");
`else
`define FFA_ASSERT_IMPL(lbl, ante, cons)
`define FFA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ sv/ffa_pkg.sv @@
// ----------------------------------------------------------------------------
// Face flux accumulator package
// Sizes, command and status codes, word types and saturating arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none
package ffa_pkg;
  localparam int DIM    = 3;
  localparam int CELLS  = 1024;
  localparam int SLOTS  = 512;
  localparam int KEYS   = CELLS * DIM * 2;
  localparam int KEY_W  = $clog2(KEYS);
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int USED_W = $clog2(SLOTS + 1);
  localparam int NACC   = 5;

  localparam logic [1:0] CMD_REG = 2'd0;
  localparam logic [1:0] CMD_REC = 2'd1;
  localparam logic [1:0] CMD_CLR = 2'd2;
  localparam logic [1:0] CMD_RD  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOKEY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [1:0]         command;
    logic [9:0]         cell_req;
    logic [1:0]         axis;
    logic               plus_side;
    logic signed [31:0] mass_flux;
    logic signed [31:0] momentum_x;
    logic signed [31:0] momentum_y;
    logic signed [31:0] momentum_z;
    logic signed [31:0] energy_flux;
    logic [31:0]        area;
    logic [8:0]         slot;
  } request_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [8:0]         slot_index;
    logic [9:0]         slot_total;
    logic [9:0]         face_cell;
    logic               face_plus;
    logic [15:0]        sample_count;
    logic signed [63:0] mean_mass;
    logic signed [63:0] mean_mom_x;
    logic signed [63:0] mean_mom_y;
    logic signed [63:0] mean_mom_z;
    logic signed [63:0] mean_energy;
  } result_t;

  // One slot row: the face it belongs to, its count and its five sums.
  typedef struct packed {
    logic [9:0]            cell_id;
    logic                  plus;
    logic [15:0]           count;
    logic [NACC-1:0][63:0] acc;
  } row_t;

  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
  } map_entry_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s;
  endfunction
endpackage
`default_nettype wire

@@ sv/ffa_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none
module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ sv/ffa_div.sv @@
// ----------------------------------------------------------------------------
// Face flux accumulator divider
// Restoring divider, 64-bit dividend by 16-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module ffa_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        go,
  input  wire logic [63:0] dividend,
  input  wire logic [15:0] divisor,
  output      logic        done,
  output      logic [63:0] quotient
);
  logic [15:0] rem;
  logic [15:0] dvs;
  logic [6:0]  cnt;
  logic        run;
  logic [16:0] trial;

  assign trial = {rem, quotient[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run      <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (run) begin
        if (trial >= {1'b0, dvs}) begin
          rem      <= 16'(trial - {1'b0, dvs});
          quotient <= {quotient[62:0], 1'b1};
        end else begin
          rem      <= trial[15:0];
          quotient <= {quotient[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ sv/face_flux_accumulator_top.sv @@
// ----------------------------------------------------------------------------
// Face flux accumulator
// Table of coarse-fine cell faces with saturating flux sums per slot.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low; exactly one
// result word comes back later on result, marked by a one-cycle done pulse
// that cannot be held off, so the receiver must take it in that cycle. The
// block handles one word at a time. After reset it first sweeps the face map
// memory, one entry per cycle, and stays busy meanwhile. A command
// rejected at once (bad key, read of an unused slot, clear of an empty
// table) is answered from the idle state. Register and a record of an
// unregistered face are answered after the face map lookup. Record then
// reads the slot row, runs the five flux-times-area products through one
// 32 by 32 multiplier with a saturating add after each, and writes the row
// back. Clear reads and rewrites every used row of the slot memory. Read
// waits on the bit-serial divider, which forms the five means one after
// another, and skips it when the count is zero. Busy is already low in the
// cycle that shows the result, so the next word may be taken there.
// ----------------------------------------------------------------------------
`default_nettype none
`include "face_flux_accumulator_top_assert.svh"
module face_flux_accumulator_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire ffa_pkg::request_t  request,
  output      logic               busy,
  output      logic               done,
  output      ffa_pkg::result_t   result
);
  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_MAP    = 4'd2;
  localparam logic [3:0] S_LOAD   = 4'd3;
  localparam logic [3:0] S_MUL    = 4'd4;
  localparam logic [3:0] S_ADD    = 4'd5;
  localparam logic [3:0] S_WB     = 4'd6;
  localparam logic [3:0] S_CLR_RD = 4'd7;
  localparam logic [3:0] S_CLR_WR = 4'd8;
  localparam logic [3:0] S_RLOAD  = 4'd9;
  localparam logic [3:0] S_DIV    = 4'd10;
  localparam logic [3:0] S_DWAIT  = 4'd11;

  localparam int MAP_W = $bits(ffa_pkg::map_entry_t);
  localparam int ROW_W = $bits(ffa_pkg::row_t);

  logic [3:0]                   state;
  ffa_pkg::request_t            req;
  logic [ffa_pkg::KEY_W-1:0]    key;
  logic [ffa_pkg::KEY_W-1:0]    init_ptr;
  logic [ffa_pkg::SLOT_W-1:0]   sidx;
  logic [ffa_pkg::USED_W-1:0]   used;
  ffa_pkg::row_t                row;
  logic [2:0]                   mi;
  logic [63:0]                  prod;
  logic                         pneg;

  // Face key of the incoming word.
  logic                         in_key_ok;
  logic [ffa_pkg::KEY_W-1:0]    in_key;

  assign in_key_ok = (32'(request.cell_req) < 32'(ffa_pkg::CELLS)) &&
                     (32'(request.axis) < 32'(ffa_pkg::DIM));
  assign in_key = ffa_pkg::KEY_W'((32'(request.cell_req) * ffa_pkg::DIM +
                  32'(request.axis)) * 2 + 32'(request.plus_side));

  // Result word loaded when a command is taken: commands rejected right away
  // carry their status from here.
  ffa_pkg::result_t             idle_result;

  always_comb begin
    idle_result            = '0;
    idle_result.slot_total = 10'(used);
    case (request.command)
      ffa_pkg::CMD_REG, ffa_pkg::CMD_REC: begin
        if (!in_key_ok) begin
          idle_result.status = ffa_pkg::ST_NOKEY;
        end
      end
      ffa_pkg::CMD_CLR: begin
      end
      default: begin
        if ({1'b0, request.slot} >= 10'(used)) begin
          idle_result.status = ffa_pkg::ST_RANGE;
        end
      end
    endcase
  end

  // Memory ports.
  logic                         map_we;
  logic [ffa_pkg::KEY_W-1:0]    map_waddr;
  ffa_pkg::map_entry_t          map_wdata;
  logic [ffa_pkg::KEY_W-1:0]    map_raddr;
  logic [MAP_W-1:0]             map_rraw;
  ffa_pkg::map_entry_t          map_rdata;
  logic                         slot_we;
  logic [ffa_pkg::SLOT_W-1:0]   slot_waddr;
  ffa_pkg::row_t                slot_wdata;
  logic [ffa_pkg::SLOT_W-1:0]   slot_raddr;
  logic [ROW_W-1:0]             slot_rraw;
  ffa_pkg::row_t                slot_rdata;

  assign map_rdata  = ffa_pkg::map_entry_t'(map_rraw);
  assign slot_rdata = ffa_pkg::row_t'(slot_rraw);

  ffa_ram #(.WIDTH(MAP_W), .DEPTH(ffa_pkg::KEYS)) u_map (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .raddr(map_raddr), .rdata(map_rraw)
  );

  ffa_ram #(.WIDTH(ROW_W), .DEPTH(ffa_pkg::SLOTS)) u_slot (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(slot_raddr), .rdata(slot_rraw)
  );

  // The face map is written during the reset sweep and when a new face gets
  // its slot; the slot memory on registration, record write-back and clear.
  logic reg_new;
  assign reg_new = (state == S_MAP) && (req.command == ffa_pkg::CMD_REG) &&
                   !map_rdata.valid && (32'(used) < 32'(ffa_pkg::SLOTS));

  always_comb begin
    map_we          = 1'b0;
    map_waddr       = key;
    map_wdata.valid = 1'b1;
    map_wdata.slot  = ffa_pkg::SLOT_W'(used);
    map_raddr       = in_key;
    slot_we         = 1'b0;
    slot_waddr      = sidx;
    slot_wdata      = row;
    slot_raddr      = request.slot;
    case (state)
      S_INIT: begin
        map_we    = 1'b1;
        map_waddr = init_ptr;
        map_wdata = '0;
      end
      S_MAP: begin
        map_we             = reg_new;
        slot_we            = reg_new;
        slot_waddr         = ffa_pkg::SLOT_W'(used);
        slot_wdata         = '0;
        slot_wdata.cell_id = req.cell_req;
        slot_wdata.plus    = req.plus_side;
        slot_raddr         = map_rdata.slot;
      end
      S_WB: begin
        slot_we = 1'b1;
      end
      S_CLR_RD: begin
        slot_raddr = sidx;
      end
      S_CLR_WR: begin
        slot_we            = 1'b1;
        slot_wdata         = '0;
        slot_wdata.cell_id = slot_rdata.cell_id;
        slot_wdata.plus    = slot_rdata.plus;
      end
      default: begin
      end
    endcase
  end

  // Flux operand for the product under way; unused momentum axes give zero.
  logic signed [31:0] flux;
  logic [31:0]        fmag;
  logic [63:0]        mul_out;

  always_comb begin
    case (mi)
      3'd0:    flux = req.mass_flux;
      3'd1:    flux = req.momentum_x;
      3'd2:    flux = (ffa_pkg::DIM > 1) ? req.momentum_y : 32'sd0;
      3'd3:    flux = (ffa_pkg::DIM > 2) ? req.momentum_z : 32'sd0;
      default: flux = req.energy_flux;
    endcase
  end

  assign fmag    = flux[31] ? (~flux + 32'd1) : flux;
  assign mul_out = 64'(fmag) * 64'(req.area);

  // Shared divider for the read means.
  logic        div_go;
  logic        div_done;
  logic [63:0] div_q;
  logic [63:0] div_mag;

  assign div_go  = (state == S_DIV);
  assign div_mag = row.acc[mi][63] ? (~row.acc[mi] + 64'd1) : row.acc[mi];

  ffa_div u_div (
    .clk(clk), .rst(rst), .go(div_go), .dividend(div_mag),
    .divisor(row.count), .done(div_done), .quotient(div_q)
  );

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      init_ptr <= '0;
      used     <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_INIT: begin
          init_ptr <= init_ptr + 1'b1;
          if (32'(init_ptr) == ffa_pkg::KEYS - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            req    <= request;
            key    <= in_key;
            sidx   <= '0;
            mi     <= '0;
            result <= idle_result;
            case (request.command)
              ffa_pkg::CMD_REG, ffa_pkg::CMD_REC: begin
                if (in_key_ok) begin
                  state <= S_MAP;
                end else begin
                  done <= 1'b1;
                end
              end
              ffa_pkg::CMD_CLR: begin
                if (used == '0) begin
                  done <= 1'b1;
                end else begin
                  state <= S_CLR_RD;
                end
              end
              default: begin
                if ({1'b0, request.slot} >= 10'(used)) begin
                  done <= 1'b1;
                end else begin
                  sidx  <= request.slot;
                  state <= S_RLOAD;
                end
              end
            endcase
          end
        end
        S_MAP: begin
          if (req.command == ffa_pkg::CMD_REG) begin
            state <= S_IDLE;
            done  <= 1'b1;
            if (map_rdata.valid) begin
              result.slot_index <= 9'(map_rdata.slot);
            end else if (reg_new) begin
              result.slot_index <= 9'(used);
              result.slot_total <= 10'(used + 1'b1);
              used              <= used + 1'b1;
            end else begin
              result.status <= ffa_pkg::ST_FULL;
            end
          end else if (map_rdata.valid) begin
            sidx  <= map_rdata.slot;
            state <= S_LOAD;
          end else begin
            result.status <= ffa_pkg::ST_NOKEY;
            state         <= S_IDLE;
            done          <= 1'b1;
          end
        end
        S_LOAD: begin
          row   <= slot_rdata;
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= mul_out;
          pneg  <= flux[31];
          state <= S_ADD;
        end
        S_ADD: begin
          row.acc[mi] <= ffa_pkg::sat_add(row.acc[mi], pneg ? (~prod + 64'd1) : prod);
          if (32'(mi) == ffa_pkg::NACC - 1) begin
            if (row.count != 16'hFFFF) begin
              row.count <= row.count + 16'd1;
            end
            state <= S_WB;
          end else begin
            mi    <= mi + 3'd1;
            state <= S_MUL;
          end
        end
        S_WB: begin
          result.slot_index <= 9'(sidx);
          state             <= S_IDLE;
          done              <= 1'b1;
        end
        S_CLR_RD: begin
          state <= S_CLR_WR;
        end
        S_CLR_WR: begin
          if (10'(sidx) == 10'(used - 1'b1)) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end else begin
            sidx  <= sidx + 1'b1;
            state <= S_CLR_RD;
          end
        end
        S_RLOAD: begin
          row                 <= slot_rdata;
          result.slot_index   <= 9'(sidx);
          result.face_cell    <= slot_rdata.cell_id;
          result.face_plus    <= slot_rdata.plus;
          result.sample_count <= slot_rdata.count;
          if (slot_rdata.count == 16'd0) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          state <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_done) begin
            // Quotient carries the sign of the sum: truncation toward zero.
            case (mi)
              3'd0: result.mean_mass <= row.acc[mi][63] ? (~div_q + 64'd1) : div_q;
              3'd1: result.mean_mom_x <= row.acc[mi][63] ? (~div_q + 64'd1) : div_q;
              3'd2: result.mean_mom_y <= (ffa_pkg::DIM < 2) ? 64'd0 :
                                         row.acc[mi][63] ? (~div_q + 64'd1) : div_q;
              3'd3: result.mean_mom_z <= (ffa_pkg::DIM < 3) ? 64'd0 :
                                         row.acc[mi][63] ? (~div_q + 64'd1) : div_q;
              default: result.mean_energy <= row.acc[mi][63] ? (~div_q + 64'd1) : div_q;
            endcase
            if (32'(mi) == ffa_pkg::NACC - 1) begin
              state <= S_IDLE;
              done  <= 1'b1;
            end else begin
              mi    <= mi + 3'd1;
              state <= S_DIV;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result only ever closes a word that was taken or kept the block busy.
  `FFA_ASSERT_IMPL(a_done_after_busy, done, $past(busy) || $past(start))
  // A taken word either holds the block busy or is answered at once.
  `FFA_ASSERT_NEXT(a_start_busy, start && !busy, busy || done)
  // The slot count never runs past the table size.
  `FFA_ASSERT_IMPL(a_used_bound, 1'b1, 32'(used) <= ffa_pkg::SLOTS)
  // A full-table status is only given when every slot is taken.
  `FFA_ASSERT_IMPL(a_full_status, done && result.status == ffa_pkg::ST_FULL,
                   32'(used) == ffa_pkg::SLOTS)
endmodule
`default_nettype wire

@@ tb/sv/ffa_checker.sv @@
// ----------------------------------------------------------------------------
// Face flux accumulator checker
// Watches the command and result words, keeps its own copy of the face
// table and slot sums, and compares every result word with its prediction.
// ----------------------------------------------------------------------------
`default_nettype none
module ffa_checker (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic              busy,
  input  wire ffa_pkg::request_t request,
  input  wire logic              done,
  input  wire ffa_pkg::result_t  result,
  output      int                fail_count,
  output      int                pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ffa_pkg::*;

  bit               face_known [KEYS];
  logic [8:0]       face_slot [KEYS];
  int unsigned      slots_used;
  logic [9:0]       row_cell [SLOTS];
  logic             row_plus [SLOTS];
  logic [15:0]      row_count [SLOTS];
  logic [63:0]      row_sum [SLOTS][NACC];
  result_t          expected_words[$];

  function automatic logic [63:0] scaled_flux(logic [31:0] flux, logic [31:0] area);
    logic [63:0] mag;
    mag = flux[31] ? 64'(-$signed({32'hFFFFFFFF, flux})) : {32'd0, flux};
    mag = mag * {32'd0, area};
    return flux[31] ? -mag : mag;
  endfunction

  function automatic logic [63:0] add_clamped(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) s = a[63] ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF;
    return s;
  endfunction

  function automatic logic [63:0] mean_value(logic [63:0] sum, logic [15:0] n);
    logic [63:0] mag;
    if (n == 0) return 64'd0;
    mag = sum[63] ? -sum : sum;
    mag = mag / {48'd0, n};
    return sum[63] ? -mag : mag;
  endfunction

  function automatic result_t predict_word(request_t q);
    result_t r;
    int key;
    int s;
    logic [31:0] flux [NACC];
    bit key_ok;
    r = '0;
    key_ok = q.axis < DIM;
    key = (q.cell_req * DIM + q.axis) * 2 + q.plus_side;
    flux[0] = q.mass_flux;  flux[1] = q.momentum_x; flux[2] = q.momentum_y;
    flux[3] = q.momentum_z; flux[4] = q.energy_flux;
    case (q.command)
      CMD_REG: begin
        if (!key_ok) r.status = ST_NOKEY;
        else if (face_known[key]) r.slot_index = face_slot[key];
        else if (slots_used >= SLOTS) r.status = ST_FULL;
        else begin
          s = slots_used;
          slots_used++;
          face_known[key] = 1'b1;
          face_slot[key] = s[8:0];
          row_cell[s] = q.cell_req;
          row_plus[s] = q.plus_side;
          row_count[s] = '0;
          for (int i = 0; i < NACC; i++) row_sum[s][i] = '0;
          r.slot_index = s[8:0];
        end
      end
      CMD_REC: begin
        if (!key_ok || !face_known[key]) r.status = ST_NOKEY;
        else begin
          s = int'(face_slot[key]);
          for (int i = 0; i < NACC; i++)
            row_sum[s][i] = add_clamped(row_sum[s][i], scaled_flux(flux[i], q.area));
          if (row_count[s] != 16'hFFFF) row_count[s]++;
          r.slot_index = s[8:0];
        end
      end
      CMD_CLR: begin
        for (int j = 0; j < SLOTS; j++) begin
          row_count[j] = '0;
          for (int i = 0; i < NACC; i++) row_sum[j][i] = '0;
        end
      end
      default: begin
        if (q.slot >= slots_used) r.status = ST_RANGE;
        else begin
          s = int'(q.slot);
          r.slot_index = q.slot;
          r.face_cell = row_cell[s];
          r.face_plus = row_plus[s];
          r.sample_count = row_count[s];
          r.mean_mass = mean_value(row_sum[s][0], row_count[s]);
          r.mean_mom_x = mean_value(row_sum[s][1], row_count[s]);
          r.mean_mom_y = mean_value(row_sum[s][2], row_count[s]);
          r.mean_mom_z = mean_value(row_sum[s][3], row_count[s]);
          r.mean_energy = mean_value(row_sum[s][4], row_count[s]);
        end
      end
    endcase
    r.slot_total = slots_used[9:0];
    return r;
  endfunction

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  assign pending = expected_words.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      slots_used = 0;
      for (int k = 0; k < KEYS; k++) face_known[k] = 0;
    end else begin
      if (start && !busy) expected_words = {expected_words, predict_word(request)};
      if (done) begin
        if (expected_words.size() == 0) begin
          $error("result word with no command waiting");
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          compare_field("status", 64'(want.status), 64'(result.status));
          compare_field("slot_index", 64'(want.slot_index), 64'(result.slot_index));
          compare_field("slot_total", 64'(want.slot_total), 64'(result.slot_total));
          compare_field("face_cell", 64'(want.face_cell), 64'(result.face_cell));
          compare_field("face_plus", 64'(want.face_plus), 64'(result.face_plus));
          compare_field("sample_count", 64'(want.sample_count),
                        64'(result.sample_count));
          compare_field("mean_mass", want.mean_mass, result.mean_mass);
          compare_field("mean_mom_x", want.mean_mom_x, result.mean_mom_x);
          compare_field("mean_mom_y", want.mean_mom_y, result.mean_mom_y);
          compare_field("mean_mom_z", want.mean_mom_z, result.mean_mom_z);
          compare_field("mean_energy", want.mean_energy, result.mean_energy);
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// Face flux accumulator testbench
// Drives directed and random command words into the block and lets the
// checker compare every result word against its own prediction.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ffa_pkg::*;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  request_t request = '0;
  logic     busy;
  logic     done;
  result_t  result;
  int       fail_count;
  int       pending;
  int       words_sent = 0;

  // A small pool of faces keeps most records landing on registered slots, so
  // the sums actually build up and saturate.
  logic [9:0] pool_cell [16];
  logic [1:0] pool_axis [16];
  logic       pool_plus [16];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  face_flux_accumulator_top u_dut (
    .clk(clk), .rst(rst), .start(start), .request(request),
    .busy(busy), .done(done), .result(result)
  );

  ffa_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .done(done), .result(result), .fail_count(fail_count), .pending(pending)
  );

  // Offer one command word: a random gap first, then hold start until the
  // block takes the word at a rising edge with busy low. All changes happen
  // at the falling edge, so the block and checker see stable inputs.
  task automatic send_word(request_t w);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
    repeat (gap) @(negedge clk);
    request <= w;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    start <= 1'b0;
    request <= '0;
    words_sent++;
  endtask

  function automatic logic [31:0] edgy_value();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'hFFFFFFFF;
      3: return 32'd0;
      default: return $urandom();
    endcase
  endfunction

  function automatic request_t random_word(int kind, int pick);
    request_t w;
    w = '0;
    w.mass_flux = edgy_value();
    w.momentum_x = edgy_value();
    w.momentum_y = edgy_value();
    w.momentum_z = edgy_value();
    w.energy_flux = edgy_value();
    w.area = edgy_value();
    w.slot = $urandom_range(0, 9) == 0 ? 9'($urandom()) : 9'($urandom_range(0, 20));
    if ($urandom_range(0, 9) == 0) begin
      // Noise: any face key, axis 3 included.
      w.cell_req = 10'($urandom());
      w.axis = 2'($urandom());
      w.plus_side = 1'($urandom());
    end else begin
      w.cell_req = pool_cell[pick];
      w.axis = pool_axis[pick];
      w.plus_side = pool_plus[pick];
    end
    case (kind)
      0: w.command = CMD_REG;
      1: w.command = CMD_REC;
      2: w.command = CMD_CLR;
      default: w.command = CMD_RD;
    endcase
    return w;
  endfunction

  initial begin
    request_t w;
    int roll;
    for (int i = 0; i < 16; i++) begin
      pool_cell[i] = 10'($urandom());
      pool_axis[i] = 2'($urandom_range(0, DIM - 1));
      pool_plus[i] = 1'($urandom());
    end
    pool_cell[0] = 10'd1023; pool_axis[0] = 2'(DIM - 1); pool_plus[0] = 1'b1;
    pool_cell[1] = 10'd0;    pool_axis[1] = 2'd0;        pool_plus[1] = 1'b0;

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed part: read of an empty table, bad axis, record of an
    // unregistered face, registration twice, extreme records, clear, reads.
    w = '0; w.command = CMD_RD; w.slot = 9'd0; send_word(w);
    w = '0; w.command = CMD_REG; w.axis = 2'd3; send_word(w);
    w = '0; w.command = CMD_REC; w.cell_req = 10'd5; send_word(w);
    for (int i = 0; i < 2; i++) begin
      w = '0; w.command = CMD_REG;
      w.cell_req = pool_cell[i]; w.axis = pool_axis[i]; w.plus_side = pool_plus[i];
      send_word(w);
      send_word(w);
    end
    // Saturation both ways: full-scale flux times full-scale area, repeated.
    for (int i = 0; i < 6; i++) begin
      w = '0; w.command = CMD_REC;
      w.cell_req = pool_cell[i % 2]; w.axis = pool_axis[i % 2]; w.plus_side = pool_plus[i % 2];
      w.area = 32'hFFFFFFFF;
      w.mass_flux = (i % 2) ? 32'h80000000 : 32'h7FFFFFFF;
      w.momentum_x = 32'h80000000; w.momentum_y = 32'h7FFFFFFF;
      w.momentum_z = 32'hFFFFFFFF; w.energy_flux = 32'h00000001;
      send_word(w);
    end
    for (int i = 0; i < 3; i++) begin
      w = '0; w.command = CMD_RD; w.slot = 9'(i); send_word(w);
    end
    w = '0; w.command = CMD_RD; w.slot = 9'd511; send_word(w);
    w = '0; w.command = CMD_CLR; w.area = 32'hFFFFFFFF; send_word(w);
    w = '0; w.command = CMD_RD; w.slot = 9'd0; send_word(w);

    // Random part, mostly records on pooled faces; clears and reads are
    // kept rarer since they are the slow commands.
    for (int n = 0; n < 90; n++) begin
      roll = $urandom_range(0, 99);
      w = random_word(roll < 15 ? 0 : roll < 75 ? 1 : roll < 78 ? 2 : 3,
                      $urandom_range(0, 15));
      send_word(w);
    end

    // Fill the table to its end and past it, then read the last slot.
    for (int c = 0; c < 172; c++) begin
      w = '0; w.command = CMD_REG; w.cell_req = 10'(c + 512);
      w.axis = 2'(c % DIM); w.plus_side = c[0];
      send_word(w);
      w.plus_side = ~c[0];
      send_word(w);
      w.axis = 2'((c + 1) % DIM);
      send_word(w);
    end
    w = '0; w.command = CMD_RD; w.slot = 9'd511; send_word(w);
    w = '0; w.command = CMD_CLR; send_word(w);

    while (pending != 0) @(negedge clk);
    repeat (400) @(negedge clk);
    $display("Sent %0d command words: registration up to a full table, records with", words_sent);
    $display("saturating sums, clears and reads of used and unused slots.");
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire

@@ face_flux_accumulator_top.f @@
+incdir+sv
sv/ffa_pkg.sv
sv/ffa_ram.sv
sv/ffa_div.sv
sv/face_flux_accumulator_top.sv
tb/sv/ffa_checker.sv
tb/sv/tb_top.sv
